[design/skf_pkg.sv]
// Package for the seed-key Feistel cipher: sizes, state codes and the
// control/status structs shared by the top level and the round-function unit.
package skf_pkg;

   localparam int SEED_ROUNDS_DEF    = 16;
   localparam int PAYLOAD_ROUNDS_DEF = 4;

   localparam int HALF_W    = 16;
   localparam int WORD_W    = 32;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 4;
   localparam int KEY_CNT   = 16;
   localparam int KEY_IDX_W = 4;
   localparam int SBOX_CNT  = 32;
   localparam int SBOX_IDX_W = 5;
   localparam int SBOX_W    = 8;
   localparam int DIGITS    = 4;
   localparam int DIGIT_W   = 4;
   localparam int NIB_CNT_W = 2;
   localparam int ROT_R     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_3   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SBOX_0_7  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SBOX_24_31 = 4'd7;

   localparam logic CMD_SEED    = 1'b0;
   localparam logic CMD_PAYLOAD = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEY,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } mix_ctl_type;

   typedef struct packed {
      logic last;
   } mix_stat_type;

endpackage

[design/seed_key_feistel_cipher_top.sv]
// Seed-key Feistel cipher, top level: register file, round sequencer, result strobe.
// Depends on skf_pkg and skf_fmix.
//
// One 32-bit word per command. Each round has a key-fetch state (ST_KEY) and
// then one step per table digit of the round function (ST_SUM), four digits,
// as the round function shares a single table read port. After the last round
// (SEED_ROUNDS, 16 by default, in seed-key mode; PAYLOAD_ROUNDS, 4 by default,
// in payload mode) comes the result state ST_DONE. A new word is accepted only
// in ST_IDLE, and busy stays high until the result
// cycle has ended; rsp_valid is high for that single cycle and the result
// is not held, so the receiver must take it then.
module seed_key_feistel_cipher_top #(
   parameter int SEED_ROUNDS    = skf_pkg::SEED_ROUNDS_DEF,
   parameter int PAYLOAD_ROUNDS = skf_pkg::PAYLOAD_ROUNDS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [skf_pkg::WORD_W-1:0]     req_data_word,
   output logic                           rsp_valid,
   output logic [skf_pkg::WORD_W-1:0]     rsp_result_word,
   input  logic                           csr_wr_en,
   input  logic [skf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [skf_pkg::CSR_W-1:0]      csr_wdata
);

   localparam int MaxRounds = (SEED_ROUNDS > PAYLOAD_ROUNDS) ? SEED_ROUNDS : PAYLOAD_ROUNDS;
   localparam int CntW      = $clog2(MaxRounds + 1);
   localparam int KeysPerCsr = skf_pkg::CSR_W / skf_pkg::HALF_W;
   localparam int SboxPerCsr = skf_pkg::CSR_W / skf_pkg::SBOX_W;

   logic [skf_pkg::HALF_W-1:0] key_ff  [skf_pkg::KEY_CNT];
   logic [skf_pkg::SBOX_W-1:0] sbox_ff [skf_pkg::SBOX_CNT];

   skf_pkg::state_type state_ff, state_in;

   logic [skf_pkg::HALF_W-1:0]    hi_ff, hi_in, lo_ff, lo_in;
   logic [CntW-1:0]               left_ff, left_in;
   logic [skf_pkg::KEY_IDX_W-1:0] kidx_ff, kidx_in;
   logic                          rev_ff, rev_in;

   skf_pkg::mix_ctl_type          mix_ctl;
   skf_pkg::mix_stat_type         mix_stat;
   logic [skf_pkg::SBOX_IDX_W-1:0] sbox_addr;
   logic [skf_pkg::HALF_W-1:0]    f_val;
   logic [skf_pkg::HALF_W-1:0]    x_val;
   logic                          accept;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < skf_pkg::KEY_CNT; i++) key_ff[i] <= '0;
         for (int i = 0; i < skf_pkg::SBOX_CNT; i++) sbox_ff[i] <= '0;
      end else if (csr_wr_en) begin
         if (csr_index < skf_pkg::CSR_SBOX_0_7) begin
            for (int i = 0; i < KeysPerCsr; i++)
               key_ff[skf_pkg::KEY_IDX_W'((csr_index[1:0] * KeysPerCsr) + i)] <=
                  csr_wdata[i*skf_pkg::HALF_W +: skf_pkg::HALF_W];
         end else if (csr_index <= skf_pkg::CSR_SBOX_24_31) begin
            for (int i = 0; i < SboxPerCsr; i++)
               sbox_ff[skf_pkg::SBOX_IDX_W'((csr_index[1:0] * SboxPerCsr) + i)] <=
                  csr_wdata[i*skf_pkg::SBOX_W +: skf_pkg::SBOX_W];
         end
      end
   end

   assign accept = start && (state_ff == skf_pkg::ST_IDLE);
   assign x_val  = lo_ff ^ key_ff[kidx_ff];

   skf_fmix u_fmix (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mix_ctl),
      .x_in      (x_val),
      .sbox_addr (sbox_addr),
      .sbox_byte (sbox_ff[sbox_addr]),
      .stat      (mix_stat),
      .f_out     (f_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skf_pkg::ST_IDLE;
         left_ff  <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      kidx_ff <= kidx_in;
      rev_ff  <= rev_in;
   end

   always_comb begin
      state_in     = state_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      left_in      = left_ff;
      kidx_in      = kidx_ff;
      rev_in       = rev_ff;
      mix_ctl.load = 1'b0;
      mix_ctl.step = 1'b0;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      case (state_ff)
         skf_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               hi_in = req_data_word[skf_pkg::WORD_W-1:skf_pkg::HALF_W];
               lo_in = req_data_word[skf_pkg::HALF_W-1:0];
               if (req_cmd == skf_pkg::CMD_PAYLOAD) begin
                  left_in = CntW'(PAYLOAD_ROUNDS);
                  kidx_in = '0;
                  rev_in  = 1'b0;
               end else begin
                  left_in = CntW'(SEED_ROUNDS);
                  kidx_in = skf_pkg::KEY_IDX_W'(SEED_ROUNDS - 1);
                  rev_in  = 1'b1;
               end
               state_in = skf_pkg::ST_KEY;
            end
         end
         skf_pkg::ST_KEY: begin
            mix_ctl.load = 1'b1;
            state_in     = skf_pkg::ST_SUM;
         end
         skf_pkg::ST_SUM: begin
            mix_ctl.step = 1'b1;
            if (mix_stat.last) begin
               hi_in   = lo_ff;
               lo_in   = f_val ^ hi_ff;
               left_in = left_ff - 1'b1;
               kidx_in = rev_ff ? (kidx_ff - 1'b1) : (kidx_ff + 1'b1);
               state_in = (left_ff == CntW'(1)) ? skf_pkg::ST_DONE : skf_pkg::ST_KEY;
            end
         end
         skf_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = skf_pkg::ST_IDLE;
         end
         default: begin
            state_in = skf_pkg::ST_IDLE;
         end
      endcase
   end

   // final swap of the halves
   assign rsp_result_word = {lo_ff, hi_ff};

`ifndef SYNTHESIS
   a_accept_to_key: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == skf_pkg::ST_KEY))
      else $error("accepted word did not start a round");
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe not a single cycle");
   a_rounds_spent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (left_ff == '0))
      else $error("result before all rounds ran");
   a_sum_has_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::ST_SUM) |-> (left_ff != '0))
      else $error("round step with no round left");
   a_key_after_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skf_pkg::ST_KEY) |=> (state_ff == skf_pkg::ST_SUM))
      else $error("key fetch not followed by digit steps");
`endif

endmodule

[design/skf_fmix.sv]
// Round function of the cipher, one 4-bit table digit per cycle while step is high.
// Holds the index shift register and the sum accumulator; uses skf_pkg.
module skf_fmix (
   input  logic                          clock,
   input  logic                          reset,
   input  skf_pkg::mix_ctl_type          ctl,
   input  logic [skf_pkg::HALF_W-1:0]    x_in,
   output logic [skf_pkg::SBOX_IDX_W-1:0] sbox_addr,
   input  logic [skf_pkg::SBOX_W-1:0]    sbox_byte,
   output skf_pkg::mix_stat_type         stat,
   output logic [skf_pkg::HALF_W-1:0]    f_out
);

   logic [skf_pkg::HALF_W:0]         x_ff;
   logic [skf_pkg::HALF_W:0]         x_in_v;
   logic [skf_pkg::HALF_W-1:0]       sum_ff;
   logic [skf_pkg::HALF_W-1:0]       sum_in;
   logic [skf_pkg::HALF_W-1:0]       term;
   logic [skf_pkg::NIB_CNT_W-1:0]    nib_ff;
   logic [skf_pkg::NIB_CNT_W-1:0]    nib_in;

   // x32 = {x, x}: slices never reach past bit 16, so only x[0] is repeated
   assign x_in_v    = {x_in[0], x_in};
   assign sbox_addr = x_ff[skf_pkg::SBOX_IDX_W-1:0];
   assign term      = skf_pkg::HALF_W'(sbox_byte) << {nib_ff, 2'b00};
   assign sum_in    = sum_ff + term;
   assign f_out     = {sum_in[skf_pkg::ROT_R-1:0], sum_in[skf_pkg::HALF_W-1:skf_pkg::ROT_R]};
   assign stat.last = (nib_ff == skf_pkg::NIB_CNT_W'(skf_pkg::DIGITS - 1));
   assign nib_in    = nib_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_ff <= '0;
      end else if (ctl.load) begin
         nib_ff <= '0;
      end else if (ctl.step) begin
         nib_ff <= nib_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff   <= x_in_v;
         sum_ff <= '0;
      end else if (ctl.step) begin
         x_ff   <= x_ff >> skf_pkg::DIGIT_W;
         sum_ff <= sum_in;
      end
   end

endmodule
